>>> design/assert_macros.svh
// Assertion macros shared by the linked list core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/adll_pkg.sv
// Shared types and constants for the array doubly linked list core.
// No dependencies; used by adll_store, adll_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package adll_pkg;

    localparam int IW = 5;                    // index field width
    localparam int VW = 32;                   // data word width
    localparam int CW = 2;                    // command field width
    localparam int SW = 2;                    // status field width
    localparam int DEFAULT_NODE_COUNT = 32;

    localparam logic [CW-1:0] CMD_INS_AFTER  = 2'd0;
    localparam logic [CW-1:0] CMD_INS_BEFORE = 2'd1;
    localparam logic [CW-1:0] CMD_DELETE     = 2'd2;

    localparam logic [SW-1:0] ST_OK       = 2'd0;
    localparam logic [SW-1:0] ST_POSITION = 2'd1;
    localparam logic [SW-1:0] ST_FULL     = 2'd2;
    localparam logic [SW-1:0] ST_UNUSED   = 2'd3;

    typedef struct packed {
        logic [IW-1:0] new_index;
        logic [SW-1:0] status;
        logic [IW-1:0] head_index;
    } t_result;

endpackage

`default_nettype wire

>>> design/adll_store.sv
// Node storage: next-link memory, prev-link memory (with in-use flag) and data memory.
// Synchronous registered reads; uses adll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adll_store #(
    parameter int NODE_COUNT = adll_pkg::DEFAULT_NODE_COUNT,
    localparam int AW = $clog2(NODE_COUNT)
) (
    input  wire logic                   i_clk,
    // next-link memory
    input  wire logic                   i_nx_rd_en,
    input  wire logic [AW-1:0]          i_nx_rd_addr,
    output logic [AW-1:0]               o_nx_rd_data,
    input  wire logic                   i_nx_wr_en,
    input  wire logic [AW-1:0]          i_nx_wr_addr,
    input  wire logic [AW-1:0]          i_nx_wr_data,
    // prev-link memory, entry is {in_use, prev}
    input  wire logic                   i_pv_rd_en,
    input  wire logic [AW-1:0]          i_pv_rd_addr,
    output logic [AW:0]                 o_pv_rd_data,
    input  wire logic                   i_pv_wr_en,
    input  wire logic [AW-1:0]          i_pv_wr_addr,
    input  wire logic [AW:0]            i_pv_wr_data,
    // data memory, write only
    input  wire logic                   i_dt_wr_en,
    input  wire logic [AW-1:0]          i_dt_wr_addr,
    input  wire logic [adll_pkg::VW-1:0] i_dt_wr_data
);
    import adll_pkg::*;

    logic [AW-1:0] r_next_mem [NODE_COUNT];
    logic [AW:0]   r_prev_mem [NODE_COUNT];
    logic [VW-1:0] r_data_mem [NODE_COUNT];
    logic [AW-1:0] r_nx_q;
    logic [AW:0]   r_pv_q;

    always_ff @(posedge i_clk) begin
        if (i_nx_wr_en) begin
            r_next_mem[i_nx_wr_addr] <= i_nx_wr_data;
        end
        if (i_nx_rd_en) begin
            r_nx_q <= r_next_mem[i_nx_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pv_wr_en) begin
            r_prev_mem[i_pv_wr_addr] <= i_pv_wr_data;
        end
        if (i_pv_rd_en) begin
            r_pv_q <= r_prev_mem[i_pv_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dt_wr_en) begin
            r_data_mem[i_dt_wr_addr] <= i_dt_wr_data;
        end
    end

    assign o_nx_rd_data = r_nx_q;
    assign o_pv_rd_data = r_pv_q;

endmodule

`default_nettype wire

>>> design/adll_ctrl.sv
// Command sequencer: reads the node links, checks the request, writes links back.
// Drives adll_store; uses adll_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adll_ctrl #(
    parameter int NODE_COUNT = adll_pkg::DEFAULT_NODE_COUNT,
    localparam int AW = $clog2(NODE_COUNT)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // request side
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [adll_pkg::CW-1:0] i_cmd,
    input  wire logic [adll_pkg::IW-1:0] i_node_index,
    input  wire logic signed [adll_pkg::VW-1:0] i_value,
    // result toward output register
    output logic                         o_res_valid,
    input  wire logic                    i_res_ready,
    output adll_pkg::t_result            o_res,
    // store ports
    output logic                         o_nx_rd_en,
    output logic [AW-1:0]                o_nx_rd_addr,
    input  wire logic [AW-1:0]           i_nx_rd_data,
    output logic                         o_nx_wr_en,
    output logic [AW-1:0]                o_nx_wr_addr,
    output logic [AW-1:0]                o_nx_wr_data,
    output logic                         o_pv_rd_en,
    output logic [AW-1:0]                o_pv_rd_addr,
    input  wire logic [AW:0]             i_pv_rd_data,
    output logic                         o_pv_wr_en,
    output logic [AW-1:0]                o_pv_wr_addr,
    output logic [AW:0]                  o_pv_wr_data,
    output logic                         o_dt_wr_en,
    output logic [AW-1:0]                o_dt_wr_addr,
    output logic [adll_pkg::VW-1:0]      o_dt_wr_data
);
    import adll_pkg::*;

    localparam int XW = (AW > IW) ? AW : IW;
    localparam logic [XW:0]   NODE_LIMIT = (XW+1)'(NODE_COUNT);
    localparam logic [AW-1:0] LAST_NODE  = AW'(NODE_COUNT - 1);

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC, S_LINK} t_state;
    typedef enum logic [2:0] {
        OP_NONE, OP_INS_EMPTY, OP_INS_AFTER, OP_INS_BEFORE, OP_DELETE
    } t_op;

    t_state        r_state;
    logic [CW-1:0] r_cmd;
    logic [IW-1:0] r_idx;
    logic [VW-1:0] r_value;
    logic          r_in_range;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_nx;
    logic [AW-1:0] r_pv;
    logic          r_inuse;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_free_head;
    logic [AW:0]   r_fill;      // entries at or above this were never written
    t_op           r_op;
    logic [AW-1:0] r_new;
    logic [SW-1:0] r_status;

    logic [XW-1:0] idx_x;
    logic          in_range;
    logic [AW-1:0] rd_addr;
    logic          accept;
    logic          fh_virgin;
    logic [AW-1:0] fh_next;
    logic          idx_zero;
    t_op           n_op;
    logic [SW-1:0] n_status;
    logic          link_go;
    logic [AW-1:0] n_head;

    assign idx_x    = XW'(i_node_index);
    assign in_range = {1'b0, idx_x} < NODE_LIMIT;
    assign rd_addr  = in_range ? idx_x[AW-1:0] : '0;
    assign accept   = (r_state == S_IDLE) && i_valid;
    assign o_stall  = (r_state != S_IDLE);

    // A never-written free node still links to its upper neighbor.
    assign fh_virgin = ({1'b0, r_free_head} >= r_fill);
    assign fh_next   = fh_virgin ? ((r_free_head == LAST_NODE) ? '0 : r_free_head + AW'(1))
                                 : i_nx_rd_data;
    assign idx_zero  = (r_idx == '0);

    // request checks, in priority order
    always_comb begin
        n_op     = OP_NONE;
        n_status = ST_OK;
        unique case (r_cmd)
            CMD_INS_AFTER: begin
                if (!r_in_range || !r_inuse) begin
                    n_status = ST_UNUSED;
                end else if (idx_zero && r_head != '0) begin
                    n_status = ST_POSITION;
                end else if (r_free_head == '0) begin
                    n_status = ST_FULL;
                end else begin
                    n_op = idx_zero ? OP_INS_EMPTY : OP_INS_AFTER;
                end
            end
            CMD_INS_BEFORE: begin
                if (!r_in_range || !r_inuse) begin
                    n_status = ST_UNUSED;
                end else if (idx_zero) begin
                    n_status = ST_POSITION;
                end else if (r_free_head == '0) begin
                    n_status = ST_FULL;
                end else begin
                    n_op = OP_INS_BEFORE;
                end
            end
            CMD_DELETE: begin
                if (!r_in_range || !r_inuse) begin
                    n_status = ST_UNUSED;
                end else if (idx_zero) begin
                    n_status = ST_POSITION;
                end else begin
                    n_op = OP_DELETE;
                end
            end
            default: begin
                n_status = ST_POSITION;
            end
        endcase
    end

    assign link_go = (r_state == S_LINK) && i_res_ready;

    // memory accesses: reads at accept and lookup, writes in two passes
    always_comb begin
        o_nx_rd_en   = 1'b0;
        o_nx_rd_addr = rd_addr;
        o_pv_rd_en   = accept;
        o_pv_rd_addr = rd_addr;
        o_nx_wr_en   = 1'b0;
        o_nx_wr_addr = '0;
        o_nx_wr_data = '0;
        o_pv_wr_en   = 1'b0;
        o_pv_wr_addr = '0;
        o_pv_wr_data = '0;
        o_dt_wr_en   = 1'b0;
        o_dt_wr_addr = '0;
        o_dt_wr_data = '0;
        n_head       = r_head;

        if (accept) begin
            o_nx_rd_en = 1'b1;
        end else if (r_state == S_LOOK) begin
            o_nx_rd_en   = 1'b1;
            o_nx_rd_addr = r_free_head;
        end

        if (r_state == S_EXEC) begin
            unique case (n_op)
                OP_INS_EMPTY, OP_INS_AFTER, OP_INS_BEFORE: begin
                    o_nx_wr_en   = 1'b1;
                    o_nx_wr_addr = r_free_head;
                    o_pv_wr_en   = 1'b1;
                    o_pv_wr_addr = r_free_head;
                    o_dt_wr_en   = 1'b1;
                    o_dt_wr_addr = r_free_head;
                    o_dt_wr_data = r_value;
                    if (n_op == OP_INS_AFTER) begin
                        o_nx_wr_data = r_nx;
                        o_pv_wr_data = {1'b1, r_addr};
                    end else if (n_op == OP_INS_BEFORE) begin
                        o_nx_wr_data = r_addr;
                        o_pv_wr_data = {1'b1, r_pv};
                    end else begin
                        o_nx_wr_data = '0;
                        o_pv_wr_data = {1'b1, AW'(0)};
                    end
                end
                OP_DELETE: begin
                    o_nx_wr_en   = 1'b1;
                    o_nx_wr_addr = r_addr;
                    o_nx_wr_data = r_free_head;
                    o_pv_wr_en   = 1'b1;
                    o_pv_wr_addr = r_addr;
                    o_pv_wr_data = '0;
                    o_dt_wr_en   = 1'b1;
                    o_dt_wr_addr = r_addr;
                    o_dt_wr_data = '0;
                end
                default: begin
                end
            endcase
        end

        if (r_state == S_LINK) begin
            unique case (r_op)
                OP_INS_AFTER: begin
                    o_nx_wr_en   = link_go;
                    o_nx_wr_addr = r_addr;
                    o_nx_wr_data = r_new;
                    o_pv_wr_en   = link_go && (r_nx != '0);
                    o_pv_wr_addr = r_nx;
                    o_pv_wr_data = {1'b1, r_new};
                end
                OP_INS_BEFORE: begin
                    o_pv_wr_en   = link_go;
                    o_pv_wr_addr = r_addr;
                    o_pv_wr_data = {1'b1, r_new};
                    o_nx_wr_en   = link_go && (r_pv != '0);
                    o_nx_wr_addr = r_pv;
                    o_nx_wr_data = r_new;
                    if (r_pv == '0) begin
                        n_head = r_new;
                    end
                end
                OP_DELETE: begin
                    o_nx_wr_en   = link_go && (r_pv != '0);
                    o_nx_wr_addr = r_pv;
                    o_nx_wr_data = r_nx;
                    o_pv_wr_en   = link_go && (r_nx != '0);
                    o_pv_wr_addr = r_nx;
                    o_pv_wr_data = {1'b1, r_pv};
                    if (r_pv == '0) begin
                        n_head = r_nx;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res_valid      = (r_state == S_LINK);
    assign o_res.new_index  = IW'(r_new);
    assign o_res.status     = r_status;
    assign o_res.head_index = IW'(n_head);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_free_head <= AW'(1);
            r_fill      <= (AW+1)'(1);
            r_op        <= OP_NONE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd      <= i_cmd;
                        r_idx      <= i_node_index;
                        r_value    <= i_value;
                        r_in_range <= in_range;
                        r_addr     <= rd_addr;
                        r_state    <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_nx    <= i_nx_rd_data;
                    r_pv    <= i_pv_rd_data[AW-1:0];
                    // sentinel always in use; unwritten entries never are
                    r_inuse <= idx_zero ||
                               (({1'b0, r_addr} < r_fill) && i_pv_rd_data[AW]);
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_op     <= n_op;
                    r_status <= n_status;
                    r_new    <= '0;
                    unique case (n_op)
                        OP_INS_EMPTY, OP_INS_AFTER, OP_INS_BEFORE: begin
                            r_new       <= r_free_head;
                            r_free_head <= fh_next;
                            if (fh_virgin) begin
                                r_fill <= r_fill + (AW+1)'(1);
                            end
                            if (n_op == OP_INS_EMPTY) begin
                                r_head <= r_free_head;
                            end
                        end
                        OP_DELETE: begin
                            r_free_head <= r_addr;
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    if (i_res_ready) begin
                        r_head  <= n_head;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/array_doubly_linked_list_core.sv
// Doubly linked list kept in node memories with a free chain; node 0 is the sentinel.
// Each accepted request runs in steps: the node's links are read, then the next link of
// the free head, then links are written back in two passes over the single write port
// of each link memory, and the result is captured in the output register. One request
// is in flight at a time; a new one is taken while the previous result still waits in
// the output register, and a stalled output holds the next request in its last pass.
// No clearing pass after reset: a fill mark stands in for the reset contents of
// unwritten entries.
// Uses adll_pkg, adll_ctrl, adll_store and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module array_doubly_linked_list_core #(
    parameter int NODE_COUNT = adll_pkg::DEFAULT_NODE_COUNT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [adll_pkg::CW-1:0]        i_cmd,
    input  wire logic [adll_pkg::IW-1:0]        i_node_index,
    input  wire logic signed [adll_pkg::VW-1:0] i_value,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [adll_pkg::IW-1:0]             o_new_index,
    output logic [adll_pkg::SW-1:0]             o_status,
    output logic [adll_pkg::IW-1:0]             o_head_index
);
    import adll_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);

    logic          res_valid;
    logic          out_free;
    t_result       res;
    t_result       r_res;
    logic          r_o_valid;

    logic          nx_rd_en;
    logic [AW-1:0] nx_rd_addr;
    logic [AW-1:0] nx_rd_data;
    logic          nx_wr_en;
    logic [AW-1:0] nx_wr_addr;
    logic [AW-1:0] nx_wr_data;
    logic          pv_rd_en;
    logic [AW-1:0] pv_rd_addr;
    logic [AW:0]   pv_rd_data;
    logic          pv_wr_en;
    logic [AW-1:0] pv_wr_addr;
    logic [AW:0]   pv_wr_data;
    logic          dt_wr_en;
    logic [AW-1:0] dt_wr_addr;
    logic [VW-1:0] dt_wr_data;

    assign out_free = !r_o_valid || !i_stall;

    adll_ctrl #(
        .NODE_COUNT (NODE_COUNT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_node_index (i_node_index),
        .i_value      (i_value),
        .o_res_valid  (res_valid),
        .i_res_ready  (out_free),
        .o_res        (res),
        .o_nx_rd_en   (nx_rd_en),
        .o_nx_rd_addr (nx_rd_addr),
        .i_nx_rd_data (nx_rd_data),
        .o_nx_wr_en   (nx_wr_en),
        .o_nx_wr_addr (nx_wr_addr),
        .o_nx_wr_data (nx_wr_data),
        .o_pv_rd_en   (pv_rd_en),
        .o_pv_rd_addr (pv_rd_addr),
        .i_pv_rd_data (pv_rd_data),
        .o_pv_wr_en   (pv_wr_en),
        .o_pv_wr_addr (pv_wr_addr),
        .o_pv_wr_data (pv_wr_data),
        .o_dt_wr_en   (dt_wr_en),
        .o_dt_wr_addr (dt_wr_addr),
        .o_dt_wr_data (dt_wr_data)
    );

    adll_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_store (
        .i_clk        (i_clk),
        .i_nx_rd_en   (nx_rd_en),
        .i_nx_rd_addr (nx_rd_addr),
        .o_nx_rd_data (nx_rd_data),
        .i_nx_wr_en   (nx_wr_en),
        .i_nx_wr_addr (nx_wr_addr),
        .i_nx_wr_data (nx_wr_data),
        .i_pv_rd_en   (pv_rd_en),
        .i_pv_rd_addr (pv_rd_addr),
        .o_pv_rd_data (pv_rd_data),
        .i_pv_wr_en   (pv_wr_en),
        .i_pv_wr_addr (pv_wr_addr),
        .i_pv_wr_data (pv_wr_data),
        .i_dt_wr_en   (dt_wr_en),
        .i_dt_wr_addr (dt_wr_addr),
        .i_dt_wr_data (dt_wr_data)
    );

    // output register; holds while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_res <= res;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_new_index  = r_res.new_index;
    assign o_status     = r_res.status;
    assign o_head_index = r_res.head_index;

    `ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `ASSERT_IMPLY(a_reject_no_node, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_new_index == '0)
    `ASSERT_IMPLY(a_insert_has_head, i_clk, i_rst_n, o_valid && o_new_index != '0, o_head_index != '0 && o_status == ST_OK)

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for array_doubly_linked_list_core: random insert/delete requests,
// an in-bench linked list predictor and an in-order result check.
// Depends on adll_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
    import adll_pkg::*;

    localparam int NODES = DEFAULT_NODE_COUNT;
    localparam logic [CW-1:0] CMD_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SEGMENTS = 8;
    localparam int SEGMENT_LEN = 80;

    typedef struct packed {
        logic [CW-1:0] cmd;
        logic [IW-1:0] idx;
        logic [VW-1:0] value;
    } t_list_cmd;

    typedef enum logic [1:0] {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
    } t_stall_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [CW-1:0]         i_cmd = '0;
    logic [IW-1:0]         i_node_index = '0;
    logic signed [VW-1:0]  i_value = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [IW-1:0]         o_new_index;
    logic [SW-1:0]         o_status;
    logic [IW-1:0]         o_head_index;

    array_doubly_linked_list_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_node_index (i_node_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_new_index  (o_new_index),
        .o_status     (o_status),
        .o_head_index (o_head_index)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted list state
    logic [IW-1:0] lst_next [NODES];
    logic [IW-1:0] lst_prev [NODES];
    bit            lst_used [NODES];
    logic [IW-1:0] lst_head;
    logic [IW-1:0] lst_free;

    t_list_cmd cmd_q[$];
    t_result   result_q[$];
    int        error_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < 100)
            $display("tb_top: %s mismatch: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // apply one accepted request to the predicted list and queue its result
    task automatic list_apply(input t_list_cmd c);
        t_result       r;
        logic [IW-1:0] n;
        logic [IW-1:0] nb;
        logic [IW-1:0] pv;
        r.new_index = '0;
        r.status    = ST_OK;
        if (c.cmd == CMD_UNKNOWN) begin
            r.status = ST_POSITION;
        end else if (!lst_used[c.idx]) begin
            r.status = ST_UNUSED;
        end else if (c.cmd == CMD_INS_AFTER) begin
            if (c.idx == 0 && lst_head != 0) begin
                r.status = ST_POSITION;
            end else if (lst_free == 0) begin
                r.status = ST_FULL;
            end else begin
                n = lst_free;
                lst_free = lst_next[n];
                lst_used[n] = 1'b1;
                if (c.idx == 0) begin
                    lst_next[n] = '0;
                    lst_prev[n] = '0;
                    lst_head = n;
                end else begin
                    nb = lst_next[c.idx];
                    lst_next[n] = nb;
                    lst_prev[n] = c.idx;
                    if (nb != 0) lst_prev[nb] = n;
                    lst_next[c.idx] = n;
                end
                r.new_index = n;
            end
        end else if (c.cmd == CMD_INS_BEFORE) begin
            if (c.idx == 0) begin
                r.status = ST_POSITION;
            end else if (lst_free == 0) begin
                r.status = ST_FULL;
            end else begin
                n = lst_free;
                lst_free = lst_next[n];
                lst_used[n] = 1'b1;
                pv = lst_prev[c.idx];
                lst_next[n] = c.idx;
                lst_prev[n] = pv;
                if (pv != 0) lst_next[pv] = n;
                else lst_head = n;
                lst_prev[c.idx] = n;
                r.new_index = n;
            end
        end else begin
            if (c.idx == 0) begin
                r.status = ST_POSITION;
            end else begin
                pv = lst_prev[c.idx];
                nb = lst_next[c.idx];
                if (pv != 0) lst_next[pv] = nb;
                else lst_head = nb;
                if (nb != 0) lst_prev[nb] = pv;
                lst_next[c.idx] = lst_free;
                lst_free = c.idx;
                lst_prev[c.idx] = '0;
                lst_used[c.idx] = 1'b0;
            end
        end
        r.head_index = lst_head;
        result_q.push_back(r);
    endtask

    // driver: bursts of random length, random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_list_cmd c;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                list_apply('{cmd: i_cmd, idx: i_node_index, value: i_value});
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    c = cmd_q.pop_front();
                    i_cmd <= c.cmd;
                    i_node_index <= c.idx;
                    i_value <= c.value;
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, mode changes when a random countdown runs out
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_cnt == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                stall_cnt <= $urandom_range(16, 96);
            end else begin
                stall_cnt <= stall_cnt - 1;
            end
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:     i_stall <= (stall_cnt % 3 == 0);
            endcase
        end
    end

    // result check against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result, new_index", o_new_index, 0);
            end else begin
                want = result_q.pop_front();
                if (o_new_index !== want.new_index)
                    report_mismatch("new_index", o_new_index, want.new_index);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_head_index !== want.head_index)
                    report_mismatch("head_index", o_head_index, want.head_index);
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("tb_top: watchdog expired");
                $display("Simulation FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // stimulus

    function automatic t_list_cmd mk(input logic [CW-1:0] cmd, input int idx,
                                     input logic [VW-1:0] value);
        t_list_cmd c;
        c.cmd = cmd;
        c.idx = IW'(idx);
        c.value = value;
        return c;
    endfunction

    function automatic logic [VW-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int count_live();
        int live;
        live = 0;
        for (int i = 1; i < NODES; i++)
            if (lst_used[i]) live++;
        return live;
    endfunction

    // mostly legal requests steered toward a target fill level, some noise
    function automatic t_list_cmd make_item(input int target);
        t_list_cmd c;
        int        live;
        int        k;
        live = count_live();
        c.value = rand_value();
        c.cmd = CW'($urandom_range(0, 3));
        c.idx = IW'($urandom_range(0, NODES - 1));
        if ($urandom_range(0, 9) < 2)
            return c;
        if (live == 0) begin
            c.cmd = CMD_INS_AFTER;
            c.idx = '0;
            return c;
        end
        k = $urandom_range(0, live - 1);
        for (int i = 1; i < NODES; i++) begin
            if (lst_used[i]) begin
                if (k == 0) c.idx = IW'(i);
                k--;
            end
        end
        if ((live <= target) == ($urandom_range(0, 3) != 0))
            c.cmd = $urandom_range(0, 1) ? CMD_INS_AFTER : CMD_INS_BEFORE;
        else
            c.cmd = CMD_DELETE;
        return c;
    endfunction

    task automatic wait_slot();
        do @(negedge i_clk); while (cmd_q.size() != 0);
    endtask

    // hold the sender until every request is accepted and every result is back
    task automatic drain();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || i_valid || result_q.size() != 0);
    endtask

    initial begin
        int target;
        for (int i = 0; i < NODES; i++) begin
            lst_next[i] = (i + 1 < NODES) ? IW'(i + 1) : '0;
            lst_prev[i] = '0;
            lst_used[i] = (i == 0);
        end
        lst_head = '0;
        lst_free = IW'(1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: sentinel rules, unused nodes, unknown command, head/tail edits
        cmd_q.push_back(mk(CMD_DELETE, 0, 32'h0));
        cmd_q.push_back(mk(CMD_INS_BEFORE, 0, 32'h1));
        cmd_q.push_back(mk(CMD_INS_AFTER, 5, 32'h2));
        cmd_q.push_back(mk(CMD_DELETE, 7, 32'h3));
        cmd_q.push_back(mk(CMD_UNKNOWN, 0, 32'h0));
        cmd_q.push_back(mk(CMD_INS_AFTER, 0, 32'h7fff_ffff));
        cmd_q.push_back(mk(CMD_INS_AFTER, 0, 32'h5555_5555));
        cmd_q.push_back(mk(CMD_INS_AFTER, 1, 32'h8000_0000));
        cmd_q.push_back(mk(CMD_INS_BEFORE, 1, 32'h0));
        cmd_q.push_back(mk(CMD_INS_BEFORE, 2, 32'hffff_ffff));
        cmd_q.push_back(mk(CMD_DELETE, 3, 32'h0));
        cmd_q.push_back(mk(CMD_DELETE, 2, 32'h0));
        cmd_q.push_back(mk(CMD_UNKNOWN, 31, 32'hffff_ffff));
        cmd_q.push_back(mk(CMD_INS_AFTER, 31, 32'haaaa_aaaa));
        cmd_q.push_back(mk(CMD_INS_BEFORE, 1, 32'h1234_5678));
        cmd_q.push_back(mk(CMD_DELETE, 1, 32'h0));
        drain();

        // insert-heavy requests aimed at a full list, then an insert before node 4
        for (int i = 0; i < 36; i++) begin
            wait_slot();
            cmd_q.push_back(make_item(NODES));
        end
        wait_slot();
        cmd_q.push_back(mk(CMD_INS_BEFORE, 4, 32'h0));
        drain();

        for (int s = 0; s < SEGMENTS; s++) begin
            case ($urandom_range(0, 3))
                0:       target = 0;
                1:       target = 3;
                2:       target = 12;
                default: target = NODES;
            endcase
            for (int i = 0; i < SEGMENT_LEN; i++) begin
                wait_slot();
                cmd_q.push_back(make_item(target));
            end
            if (s % 2 == 1) drain();
        end

        drain();
        repeat (12) @(posedge i_clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/adll_pkg.sv
design/adll_store.sv
design/adll_ctrl.sv
design/array_doubly_linked_list_core.sv
tb/tb_top.sv
